>>> rtl/core/graph_bfs_dfs_traversal_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the graph traversal core
// Concurrent assertion wrappers clocked on clk; compiled out under ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_DFS_TRAVERSAL_CORE_DEFINES_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked outside reset only
`define GBDT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Checked at every edge, reset included
`define GBDT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define GBDT_ASSERT(lbl, prop)
`define GBDT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/core/gbdt_pkg.sv
// ----------------------------------------------------------------------------
// gbdt_pkg
// Shared types, constants and helper functions of the graph traversal core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbdt_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VERT_W       = $clog2(MAX_VERTICES);
    localparam int PTR_W        = $clog2(MAX_VERTICES + 1);
    localparam int CNT_W        = 7;
    localparam int ROW_W        = MAX_VERTICES;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_BFS   = 2'd2,
        REQ_DFS   = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_WR,
        ST_B_POP,
        ST_B_U,
        ST_B_EXP,
        ST_B_ENQ,
        ST_D_TOP,
        ST_D_U,
        ST_D_EVAL,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [VERT_W-1:0] rd_addr;
        logic              wr_en;
        logic [VERT_W-1:0] wr_addr;
        logic [ROW_W-1:0]  wr_data;
    } adj_req_t;

    typedef struct packed {
        logic              valid;
        logic [VERT_W-1:0] vertex;
        logic              last;
        logic              error;
    } emit_t;

    // Cap the configured count at the array size
    function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] vc);
        return (vc > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vc;
    endfunction

    // One bit per vertex below n
    function automatic logic [ROW_W-1:0] range_mask(input logic [CNT_W-1:0] n);
        logic [ROW_W-1:0] m;
        for (int j = 0; j < MAX_VERTICES; j++)
        begin
            m[j] = (CNT_W'(j) < n);
        end
        return m;
    endfunction

    // Index of the lowest set bit: isolate it, then OR the indices together
    function automatic logic [VERT_W-1:0] lowest_index(input logic [ROW_W-1:0] bits);
        logic [ROW_W-1:0]  iso;
        logic [VERT_W-1:0] idx;
        iso = bits & (~bits + ROW_W'(1));
        idx = '0;
        for (int j = 0; j < MAX_VERTICES; j++)
        begin
            if (iso[j])
            begin
                idx = idx | VERT_W'(j);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/core/gbdt_ram.sv
// ----------------------------------------------------------------------------
// gbdt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/gbdt_adj_store.sv
// ----------------------------------------------------------------------------
// gbdt_adj_store
// Adjacency matrix: one row per source vertex, with per-row valid bits so
// that a clear takes effect at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbdt_adj_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gbdt_pkg::adj_req_t           adj_req,
    output logic [gbdt_pkg::ROW_W-1:0]   row
);

    import gbdt_pkg::*;

    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic [MAX_VERTICES-1:0] row_valid_next;
    logic                    hit_reg;
    logic [ROW_W-1:0]        ram_rdata;

    gbdt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_req.wr_en),
        .waddr (adj_req.wr_addr),
        .wdata (adj_req.wr_data),
        .re    (adj_req.rd_en),
        .raddr (adj_req.rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (adj_req.clear)
        begin
            row_valid_next = '0;
        end
        else if (adj_req.wr_en)
        begin
            row_valid_next[adj_req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            if (adj_req.rd_en)
            begin
                hit_reg <= row_valid_reg[adj_req.rd_addr];
            end
        end
    end

    // A row never written since the last clear reads as empty
    assign row = hit_reg ? ram_rdata : '0;

endmodule

>>> rtl/core/gbdt_seq.sv
// ----------------------------------------------------------------------------
// gbdt_seq
// Request sequencer: edge updates, BFS queue and DFS stack walks over the
// adjacency store, with one pending result held back to mark the last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "graph_bfs_dfs_traversal_core_defines.svh"

module gbdt_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic [gbdt_pkg::VERT_W-1:0]   from_vertex,
    input  logic [gbdt_pkg::VERT_W-1:0]   to_vertex,
    input  logic [gbdt_pkg::VERT_W-1:0]   start_vertex,
    input  logic [gbdt_pkg::CNT_W-1:0]    vertex_count,
    output gbdt_pkg::adj_req_t            adj_req,
    input  logic [gbdt_pkg::ROW_W-1:0]    adj_row,
    output gbdt_pkg::emit_t               emit,
    input  logic                          out_slot_free
);

    import gbdt_pkg::*;

    state_t              state_reg,    state_next;
    logic [PTR_W-1:0]    head_reg,     head_next;
    logic [PTR_W-1:0]    tail_reg,     tail_next;
    logic [ROW_W-1:0]    visited_reg,  visited_next;
    logic [ROW_W-1:0]    cand_reg,     cand_next;
    logic [VERT_W-1:0]   u_reg,        u_next;
    logic [VERT_W-1:0]   to_reg,       to_next;
    logic [VERT_W-1:0]   pend_vtx_reg, pend_vtx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_err_reg,   pend_err_next;

    logic                wl_we;
    logic [VERT_W-1:0]   wl_waddr;
    logic [VERT_W-1:0]   wl_wdata;
    logic                wl_re;
    logic [VERT_W-1:0]   wl_raddr;
    logic [VERT_W-1:0]   wl_rdata;

    logic [CNT_W-1:0]    n;
    logic [ROW_W-1:0]    live;
    logic [ROW_W-1:0]    pick_src;
    logic [VERT_W-1:0]   pick;
    logic [ROW_W-1:0]    pick_bit;
    logic [PTR_W-1:0]    tail_dec;
    logic                emit_ok;

    gbdt_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_VERTICES)
    ) u_work_list (
        .clk   (clk),
        .we    (wl_we),
        .waddr (wl_waddr),
        .wdata (wl_wdata),
        .re    (wl_re),
        .raddr (wl_raddr),
        .rdata (wl_rdata)
    );

    assign n        = active_count(vertex_count);
    assign live     = adj_row & range_mask(n) & ~visited_reg;
    assign pick_src = (state_reg == ST_D_EVAL) ? live : cand_reg;
    assign pick     = lowest_index(pick_src);
    assign pick_bit = ROW_W'(1) << pick;
    assign tail_dec = tail_reg - PTR_W'(1);
    // a held-back result may only move on when the output stage can take it
    assign emit_ok  = !pend_valid_reg || out_slot_free;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        visited_next    = visited_reg;
        cand_next       = cand_reg;
        u_next          = u_reg;
        to_next         = to_reg;
        pend_vtx_next   = pend_vtx_reg;
        pend_valid_next = pend_valid_reg;
        pend_err_next   = pend_err_reg;
        in_ready        = 1'b0;
        adj_req         = '0;
        emit            = '0;
        wl_we           = 1'b0;
        wl_waddr        = '0;
        wl_wdata        = '0;
        wl_re           = 1'b0;
        wl_raddr        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (req_t'(req_type))
                        REQ_CLEAR:
                        begin
                            adj_req.clear = 1'b1;
                        end
                        REQ_ADD:
                        begin
                            if ((CNT_W'(from_vertex) < n) && (CNT_W'(to_vertex) < n))
                            begin
                                adj_req.rd_en   = 1'b1;
                                adj_req.rd_addr = from_vertex;
                                u_next          = from_vertex;
                                to_next         = to_vertex;
                                state_next      = ST_ADD_WR;
                            end
                        end
                        REQ_BFS, REQ_DFS:
                        begin
                            if (CNT_W'(start_vertex) >= n)
                            begin
                                pend_vtx_next   = '0;
                                pend_valid_next = 1'b1;
                                pend_err_next   = 1'b1;
                                state_next      = ST_FLUSH;
                            end
                            else
                            begin
                                visited_next  = ROW_W'(1) << start_vertex;
                                wl_we         = 1'b1;
                                wl_waddr      = '0;
                                wl_wdata      = start_vertex;
                                head_next     = '0;
                                tail_next     = PTR_W'(1);
                                pend_err_next = 1'b0;
                                if (req_t'(req_type) == REQ_BFS)
                                begin
                                    state_next = ST_B_POP;
                                end
                                else
                                begin
                                    // DFS reports the start vertex before any walk
                                    pend_vtx_next   = start_vertex;
                                    pend_valid_next = 1'b1;
                                    state_next      = ST_D_TOP;
                                end
                            end
                        end
                    endcase
                end
            end

            ST_ADD_WR:
            begin
                adj_req.wr_en   = 1'b1;
                adj_req.wr_addr = u_reg;
                adj_req.wr_data = adj_row | (ROW_W'(1) << to_reg);
                state_next      = ST_IDLE;
            end

            ST_B_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    wl_re      = 1'b1;
                    wl_raddr   = head_reg[VERT_W-1:0];
                    head_next  = head_reg + PTR_W'(1);
                    state_next = ST_B_U;
                end
            end

            ST_B_U:
            begin
                if (emit_ok)
                begin
                    emit.valid      = pend_valid_reg;
                    emit.vertex     = pend_vtx_reg;
                    pend_vtx_next   = wl_rdata;
                    pend_valid_next = 1'b1;
                    u_next          = wl_rdata;
                    adj_req.rd_en   = 1'b1;
                    adj_req.rd_addr = wl_rdata;
                    state_next      = ST_B_EXP;
                end
            end

            ST_B_EXP:
            begin
                cand_next  = live;
                state_next = ST_B_ENQ;
            end

            ST_B_ENQ:
            begin
                if (cand_reg == '0)
                begin
                    state_next = ST_B_POP;
                end
                else
                begin
                    visited_next = visited_reg | pick_bit;
                    cand_next    = cand_reg & ~pick_bit;
                    if (tail_reg < PTR_W'(MAX_VERTICES))
                    begin
                        wl_we     = 1'b1;
                        wl_waddr  = tail_reg[VERT_W-1:0];
                        wl_wdata  = pick;
                        tail_next = tail_reg + PTR_W'(1);
                    end
                end
            end

            ST_D_TOP:
            begin
                if (tail_reg == '0)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    wl_re      = 1'b1;
                    wl_raddr   = tail_dec[VERT_W-1:0];
                    state_next = ST_D_U;
                end
            end

            ST_D_U:
            begin
                u_next          = wl_rdata;
                adj_req.rd_en   = 1'b1;
                adj_req.rd_addr = wl_rdata;
                state_next      = ST_D_EVAL;
            end

            ST_D_EVAL:
            begin
                if (live == '0)
                begin
                    tail_next  = tail_dec;
                    state_next = ST_D_TOP;
                end
                else if (emit_ok)
                begin
                    emit.valid      = pend_valid_reg;
                    emit.vertex     = pend_vtx_reg;
                    pend_vtx_next   = pick;
                    pend_valid_next = 1'b1;
                    visited_next    = visited_reg | pick_bit;
                    if (tail_reg < PTR_W'(MAX_VERTICES))
                    begin
                        // descend: the new vertex is the top, fetch its row
                        wl_we           = 1'b1;
                        wl_waddr        = tail_reg[VERT_W-1:0];
                        wl_wdata        = pick;
                        tail_next       = tail_reg + PTR_W'(1);
                        u_next          = pick;
                        adj_req.rd_en   = 1'b1;
                        adj_req.rd_addr = pick;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_slot_free)
                begin
                    emit.valid      = 1'b1;
                    emit.vertex     = pend_vtx_reg;
                    emit.last       = 1'b1;
                    emit.error      = pend_err_reg;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            visited_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            visited_reg    <= visited_next;
            pend_valid_reg <= pend_valid_next;
            pend_err_reg   <= pend_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        u_reg        <= u_next;
        to_reg       <= to_next;
        pend_vtx_reg <= pend_vtx_next;
    end

    `GBDT_ASSERT(a_idle_no_pending, (state_reg == ST_IDLE) |-> !pend_valid_reg)
    `GBDT_ASSERT(a_list_bounds, (head_reg <= tail_reg) && (tail_reg <= PTR_W'(MAX_VERTICES)))
    `GBDT_ASSERT(a_push_unvisited, (wl_we && (state_reg != ST_IDLE)) |-> !visited_reg[wl_wdata])
    `GBDT_ASSERT(a_emit_not_last_mid_walk, (emit.valid && (state_reg != ST_FLUSH)) |=> pend_valid_reg)

endmodule

>>> rtl/core/graph_bfs_dfs_traversal_core.sv
// ----------------------------------------------------------------------------
// Graph traversal core
// Directed graph held as an adjacency bit matrix; BFS and DFS visit streams.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request per transfer: clear
//   graph, add edge (from_vertex -> to_vertex), run BFS or run DFS from
//   start_vertex. Only traversals produce results; the output channel
//   (out_valid/out_ready) gives one transfer per visited vertex, with last
//   on the final one. An out-of-range start gives a single transfer with
//   visited_vertex 0, last and error set.
//   vertex_count is written through cfg_wr_en/cfg_wr_data while idle; the
//   user must keep to this; the core does not enforce it. A clear acts at
//   once; an add edge reads the row, then ORs in the new bit and writes it
//   back. BFS pops a vertex from its queue, reads its row and enqueues each
//   discovered neighbour; DFS descends straight from the row it has read,
//   and a backtrack pops the stack and rereads the row of the new top. Walk
//   steps go through the registered reads of the adjacency and work-list
//   memories. Each result is held back until the next vertex is found (or
//   the end of the walk), since last is known only then.
//   Reset empties the graph at once via per-row valid bits and sets
//   vertex_count to 64. A stalled receiver holds the output register; the
//   walk then waits at its next result and resumes when the transfer goes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "graph_bfs_dfs_traversal_core_defines.svh"

module graph_bfs_dfs_traversal_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic [gbdt_pkg::VERT_W-1:0]   from_vertex,
    input  logic [gbdt_pkg::VERT_W-1:0]   to_vertex,
    input  logic [gbdt_pkg::VERT_W-1:0]   start_vertex,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gbdt_pkg::VERT_W-1:0]   visited_vertex,
    output logic                          last,
    output logic                          error,
    input  logic                          cfg_wr_en,
    input  logic [gbdt_pkg::CNT_W-1:0]    cfg_wr_data
);

    import gbdt_pkg::*;

    // Configuration: vertex count in use
    logic [CNT_W-1:0]  vcount_reg;

    // Output register
    logic              out_valid_reg;
    logic [VERT_W-1:0] out_vertex_reg;
    logic              out_last_reg;
    logic              out_error_reg;

    adj_req_t          adj_req;
    logic [ROW_W-1:0]  adj_row;
    emit_t             emit;
    logic              slot_free;

    // Slot frees in the same cycle the receiver takes the current result
    assign slot_free = !out_valid_reg || out_ready;

    gbdt_adj_store u_adj_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .adj_req (adj_req),
        .row     (adj_row)
    );

    gbdt_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .from_vertex   (from_vertex),
        .to_vertex     (to_vertex),
        .start_vertex  (start_vertex),
        .vertex_count  (vcount_reg),
        .adj_req       (adj_req),
        .adj_row       (adj_row),
        .emit          (emit),
        .out_slot_free (slot_free)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= CNT_W'(MAX_VERTICES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vcount_reg <= cfg_wr_data;
            end
            // load a fresh result, or drop the valid once transferred
            if (emit.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_vertex_reg <= emit.vertex;
            out_last_reg   <= emit.last;
            out_error_reg  <= emit.error;
        end
    end

    assign out_valid      = out_valid_reg;
    assign visited_vertex = out_vertex_reg;
    assign last           = out_last_reg;
    assign error          = out_error_reg;

    `GBDT_ASSERT(a_emit_has_slot, emit.valid |-> slot_free)
    `GBDT_ASSERT(a_no_accept_while_busy, (in_valid && in_ready) |=> !emit.valid || !in_ready)
    `GBDT_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_reg)

endmodule

>>> dv/graph_bfs_dfs_traversal_core_tb.sv
// ----------------------------------------------------------------------------
// Graph traversal core testbench
// Drives clear, add-edge, BFS and DFS requests through the valid/ready input
// channel, predicts every visit stream from a private copy of the adjacency
// matrix and the vertex count, and checks each output transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_bfs_dfs_traversal_core_tb;

    import gbdt_pkg::*;

    // Cycles to let an add-edge or clear finish after the last visit is out
    localparam int DRAIN_SETTLE  = 16;
    // Length of the long output hold used to back the core up
    localparam int LONG_HOLD     = 400;
    // Random phases stop once this many requests have been sent overall
    localparam int RANDOM_TARGET = 265;

    typedef struct packed {
        logic [VERT_W-1:0] vertex;
        logic              last;
        logic              error;
    } visit_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        req_type = REQ_CLEAR;
    logic [VERT_W-1:0] from_vertex = '0;
    logic [VERT_W-1:0] to_vertex = '0;
    logic [VERT_W-1:0] start_vertex = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [VERT_W-1:0] visited_vertex;
    logic              last;
    logic              error;
    logic              cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]  cfg_wr_data = '0;

    // Private copy of the graph and of the count register
    logic [ROW_W-1:0]  edge_rows [MAX_VERTICES];
    logic [CNT_W-1:0]  vertex_limit;

    // Visits still owed by the core, oldest first
    visit_t            pending_visits [$];

    int                failures       = 0;
    int                requests_sent  = 0;
    int                walks_sent     = 0;
    int                visits_checked = 0;
    int                count_writes   = 0;
    bit                no_idle        = 1'b0;
    int                long_hold_cycles = 0;

    graph_bfs_dfs_traversal_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .from_vertex    (from_vertex),
        .to_vertex      (to_vertex),
        .start_vertex   (start_vertex),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .visited_vertex (visited_vertex),
        .last           (last),
        .error          (error),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic logic [VERT_W-1:0] first_neighbour(input logic [ROW_W-1:0] bits);
        logic [VERT_W-1:0] idx;
        idx = '0;
        // Scan downwards so the lowest set bit wins
        for (int j = MAX_VERTICES - 1; j >= 0; j--)
        begin
            if (bits[j])
            begin
                idx = VERT_W'(j);
            end
        end
        return idx;
    endfunction

    // Apply one accepted request to the private graph and queue the visits
    // that it owes. The work array serves as BFS queue or DFS stack; depth is
    // the queue tail for BFS and the stack depth for DFS.
    function automatic void predict_request(input req_t kind,
                                            input logic [VERT_W-1:0] src,
                                            input logic [VERT_W-1:0] dst,
                                            input logic [VERT_W-1:0] root);
        logic [CNT_W-1:0]  n;
        logic [ROW_W-1:0]  in_range;
        logic [ROW_W-1:0]  seen;
        logic [ROW_W-1:0]  cand;
        logic [VERT_W-1:0] work [MAX_VERTICES];
        logic [VERT_W-1:0] u;
        logic [VERT_W-1:0] v;
        int                head;
        int                depth;
        visit_t            walk [$];
        n = (vertex_limit > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vertex_limit;
        in_range = (n >= CNT_W'(MAX_VERTICES)) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
        case (kind)
            REQ_CLEAR:
            begin
                for (int i = 0; i < MAX_VERTICES; i++)
                begin
                    edge_rows[i] = '0;
                end
            end
            REQ_ADD:
            begin
                // Drop edges with an endpoint outside the active range
                if (CNT_W'(src) < n && CNT_W'(dst) < n)
                begin
                    edge_rows[src][dst] = 1'b1;
                end
            end
            default:
            begin
                if (CNT_W'(root) >= n)
                begin
                    walk.push_back('{vertex: '0, last: 1'b1, error: 1'b1});
                end
                else
                begin
                    seen    = ROW_W'(1) << root;
                    work[0] = root;
                    head    = 0;
                    depth   = 1;
                    if (kind == REQ_BFS)
                    begin
                        while (head != depth && walk.size() < MAX_VERTICES)
                        begin
                            u = work[head];
                            head++;
                            walk.push_back('{vertex: u, last: 1'b0, error: 1'b0});
                            cand = edge_rows[u] & in_range & ~seen;
                            while (cand != '0)
                            begin
                                v = first_neighbour(cand);
                                seen[v] = 1'b1;
                                if (depth < MAX_VERTICES)
                                begin
                                    work[depth] = v;
                                    depth++;
                                end
                                cand = cand & (cand - ROW_W'(1));
                            end
                        end
                    end
                    else
                    begin
                        walk.push_back('{vertex: root, last: 1'b0, error: 1'b0});
                        while (depth > 0)
                        begin
                            u = work[depth - 1];
                            cand = edge_rows[u] & in_range & ~seen;
                            if (cand != '0 && walk.size() < MAX_VERTICES)
                            begin
                                // Descend into the lowest unvisited neighbour
                                v = first_neighbour(cand);
                                seen[v] = 1'b1;
                                walk.push_back('{vertex: v, last: 1'b0, error: 1'b0});
                                if (depth < MAX_VERTICES)
                                begin
                                    work[depth] = v;
                                    depth++;
                                end
                            end
                            else
                            begin
                                // Nothing left below this vertex: backtrack
                                depth--;
                            end
                        end
                    end
                    walk[walk.size() - 1].last = 1'b1;
                end
                foreach (walk[i])
                begin
                    pending_visits.push_back(walk[i]);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Output side: receiver stalls and the visit checker
    // ------------------------------------------------------------------------

    // Receiver: random stall bursts, plus a long hold on request from a test
    initial
    begin
        int hold_left;
        int stall_left;
        logic rdy;
        hold_left  = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_cycles > 0)
            begin
                hold_left        = long_hold_cycles;
                long_hold_cycles = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
            end
            out_ready <= rdy;
        end
    end

    // Compare every output transfer with the oldest owed visit
    always @(posedge clk)
    begin
        visit_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_visits.size() == 0)
            begin
                $display("%0t: unexpected visit: expected none, actual vertex %0d last %0b error %0b",
                         $time, visited_vertex, last, error);
                failures++;
            end
            else
            begin
                want = pending_visits.pop_front();
                visits_checked++;
                if (visited_vertex !== want.vertex)
                begin
                    $display("%0t: visited_vertex mismatch: expected %0d actual %0d",
                             $time, want.vertex, visited_vertex);
                    failures++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last mismatch: expected %0b actual %0b",
                             $time, want.last, last);
                    failures++;
                end
                if (error !== want.error)
                begin
                    $display("%0t: error mismatch: expected %0b actual %0b",
                             $time, want.error, error);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one request and hold it until the transfer; valid stays high on
    // return so the next request can follow in the same cycle.
    task automatic send_request(input req_t kind,
                                input logic [VERT_W-1:0] src,
                                input logic [VERT_W-1:0] dst,
                                input logic [VERT_W-1:0] root);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        from_vertex  <= src;
        to_vertex    <= dst;
        start_vertex <= root;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_request(kind, src, dst, root);
        requests_sent++;
        if (kind == REQ_BFS || kind == REQ_DFS)
        begin
            walks_sent++;
        end
    endtask

    task automatic add_edge(input int src, input int dst);
        send_request(REQ_ADD, VERT_W'(src), VERT_W'(dst), VERT_W'($urandom));
    endtask

    task automatic run_walk(input req_t kind, input int root);
        send_request(kind, VERT_W'($urandom), VERT_W'($urandom), VERT_W'(root));
    endtask

    task automatic clear_graph();
        send_request(REQ_CLEAR, VERT_W'($urandom), VERT_W'($urandom), VERT_W'($urandom));
    endtask

    // Drop valid, wait for every owed visit, then let a trailing add or
    // clear finish inside the core
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_visits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    // Write the count register; only ever done with the core idle
    task automatic write_vertex_count(input logic [CNT_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        vertex_limit = value;
        count_writes++;
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked graph: empty walks, duplicates, self loop, cycles, range
    // checks on edges and start vertex, a lowered count, zero and capped
    // counts, and a clear
    task automatic test_directed();
        run_walk(REQ_BFS, 0);
        run_walk(REQ_DFS, 63);
        add_edge(0, 1);
        add_edge(0, 2);
        add_edge(1, 3);
        add_edge(2, 3);
        add_edge(3, 0);
        add_edge(0, 1);
        add_edge(5, 5);
        add_edge(63, 62);
        add_edge(62, 0);
        add_edge(3, 5);
        run_walk(REQ_BFS, 0);
        run_walk(REQ_DFS, 0);
        run_walk(REQ_BFS, 63);
        run_walk(REQ_DFS, 5);
        // Lower the count: vertex 4 and above drop out of every walk
        write_vertex_count(CNT_W'(4));
        add_edge(3, 4);
        add_edge(4, 0);
        run_walk(REQ_DFS, 63);
        run_walk(REQ_BFS, 0);
        // A zero count rejects every edge and every start
        write_vertex_count(CNT_W'(0));
        run_walk(REQ_BFS, 0);
        add_edge(0, 0);
        // Counts above the array size are capped
        write_vertex_count(CNT_W'(127));
        run_walk(REQ_DFS, 63);
        clear_graph();
        run_walk(REQ_BFS, 3);
    endtask

    // Random graphs under a series of counts: mostly well-formed edges (long
    // chains to give deep walks), some noise edges, stray clears and starts
    // that may fall out of range
    task automatic test_random_graphs();
        int unsigned preset_counts [5] = '{1, 2, 127, 64, 7};
        int phase;
        int cnt;
        int n_eff;
        int edges;
        int walks;
        int cursor;
        int src;
        phase = 0;
        while (requests_sent < RANDOM_TARGET)
        begin
            if (phase < 5)
            begin
                cnt = preset_counts[phase];
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: cnt = $urandom_range(1, 16);
                    6, 7:             cnt = $urandom_range(17, 64);
                    default:          cnt = $urandom_range(65, 127);
                endcase
            end
            phase++;
            write_vertex_count(CNT_W'(cnt));
            n_eff = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
            clear_graph();
            edges = (n_eff <= 16) ? $urandom_range(n_eff, 2 * n_eff + 2)
                                  : $urandom_range(16, 40);
            cursor = $urandom_range(0, n_eff - 1);
            for (int i = 0; i < edges; i++)
            begin
                case ($urandom_range(0, 7))
                    0:
                    begin
                        add_edge($urandom_range(0, 63), $urandom_range(0, 63));
                    end
                    1, 2, 3:
                    begin
                        add_edge(cursor, (cursor + 1) % n_eff);
                        cursor = (cursor + 1) % n_eff;
                    end
                    default:
                    begin
                        src = $urandom_range(0, n_eff - 1);
                        add_edge(src, $urandom_range(0, n_eff - 1));
                    end
                endcase
            end
            walks = $urandom_range(3, 7);
            for (int i = 0; i < walks; i++)
            begin
                case ($urandom_range(0, 19))
                    0:       clear_graph();
                    1, 2:    add_edge($urandom_range(0, n_eff - 1), $urandom_range(0, n_eff - 1));
                    default: ;
                endcase
                if ($urandom_range(0, 7) == 0)
                begin
                    run_walk(req_t'($urandom_range(2, 3)), $urandom_range(0, 63));
                end
                else
                begin
                    run_walk(req_t'($urandom_range(2, 3)), $urandom_range(0, n_eff - 1));
                end
            end
        end
    endtask

    // Hold the receiver off for a long stretch while walks keep coming, so
    // the core backs up and drops in_ready
    task automatic test_output_backpressure();
        write_vertex_count(CNT_W'(8));
        clear_graph();
        for (int i = 0; i < 8; i++)
        begin
            add_edge(i, (i + 1) % 8);
        end
        add_edge(0, 4);
        long_hold_cycles = LONG_HOLD;
        for (int i = 0; i < 6; i++)
        begin
            run_walk(i[0] ? REQ_DFS : REQ_BFS, i);
        end
    endtask

    // Let each walk drain completely before the next is offered
    task automatic test_sender_pause();
        for (int i = 0; i < 3; i++)
        begin
            run_walk(req_t'($urandom_range(2, 3)), $urandom_range(0, 7));
            wait_drained();
        end
    endtask

    // Final stretch with no idling on either side
    task automatic test_back_to_back();
        write_vertex_count(CNT_W'(64));
        no_idle = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                add_edge($urandom_range(0, 63), $urandom_range(0, 63));
            end
            else
            begin
                run_walk(req_t'($urandom_range(2, 3)), $urandom_range(0, 63));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            edge_rows[i] = '0;
        end
        vertex_limit = CNT_W'(64);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_graphs();
        test_output_backpressure();
        test_sender_pause();
        test_back_to_back();

        wait_drained();
        repeat (DRAIN_SETTLE) @(posedge clk);

        $display("Summary: %0d requests (%0d BFS/DFS walks), %0d visits checked, %0d count writes",
                 requests_sent, walks_sent, visits_checked, count_writes);
        $display("Summary: counts 0 to 127, range checks, long output hold, drained pauses, back-to-back");
        if (failures == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run
    initial
    begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/gbdt_pkg.sv
rtl/core/gbdt_ram.sv
rtl/core/gbdt_adj_store.sv
rtl/core/gbdt_seq.sv
rtl/core/graph_bfs_dfs_traversal_core.sv
dv/graph_bfs_dfs_traversal_core_tb.sv
